@@ hw/rtl/assert_macros.svh @@
// Assertion helpers used by the datapath.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property at every rising clock edge outside reset.
`define MSPID_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("mspid: assertion failed");

// Checks that a condition in one cycle implies a consequence in the next.
`define MSPID_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mspid: assertion failed");

`endif

@@ hw/rtl/mspid_pkg.sv @@
`default_nettype none
package mspid_pkg;

  localparam int GAIN_FRAC_BITS_DEF = 12;
  localparam int INTEGRAL_WIDTH_DEF = 40;

  // Configuration port.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam logic [CFG_IDX_W-1:0] CFG_RPM_PER_STEP  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_STEPS     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_P        = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_I        = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_D        = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_SPEED_LIMIT   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_PULSE_TIMEOUT = 3'd6;

  localparam logic [7:0]  RST_RPM_PER_STEP  = 8'd48;
  localparam logic [6:0]  RST_MAX_STEPS     = 7'd100;
  localparam logic [15:0] RST_GAIN          = 16'd410;
  localparam logic [15:0] RST_SPEED_LIMIT   = 16'd4800;
  localparam logic [31:0] RST_PULSE_TIMEOUT = 32'd2000000;

  typedef enum logic [1:0] {
    MODE_ENCODER = 2'd0,
    MODE_PULSE   = 2'd1,
    MODE_CONTROL = 2'd2,
    MODE_UNUSED  = 2'd3
  } mode_t;

  // Shared shift-add multiplier: two multiplier bits per cycle.
  localparam int MUL_B_W   = 16;
  localparam int MUL_STEPS = MUL_B_W / 2;
  localparam int MUL_CNT_W = $clog2(MUL_STEPS);

  // Restoring divider for the pulse period: one quotient bit per cycle.
  localparam int DIV_NUM_W = 23;
  localparam int DIV_DEN_W = 32;
  localparam int DIV_CNT_W = $clog2(DIV_NUM_W);
  localparam logic [DIV_NUM_W-1:0] RPM_NUMERATOR  = 23'd6000000;
  localparam logic [31:0]          MIN_PERIOD_US  = 32'd1000;

  // Division of the drive value by 1000 as a multiply by ceil(2^28 / 1000).
  // It is exact for every dividend below 2^18.
  localparam int DRIVE_NUM_W   = 18;
  localparam int DRIVE_RECIP_W = 19;
  localparam int DRIVE_SHIFT   = 28;
  localparam logic [DRIVE_RECIP_W-1:0] DRIVE_RECIP = 19'd268436;

  localparam int N_W = 64;
  localparam logic [7:0] DRIVE_MAX = 8'd255;

  typedef enum logic [2:0] {
    MUL_NONE  = 3'd0,
    MUL_EMS   = 3'd1,
    MUL_DMS   = 3'd2,
    MUL_PROP  = 3'd3,
    MUL_INTEG = 3'd4,
    MUL_DERIV = 3'd5
  } mul_op_t;

  typedef struct packed {
    logic    load;
    logic    enc;
    logic    pulse_arm;
    logic    pulse_upd;
    logic    use_quot;
    logic    div_start;
    logic    pid_init;
    mul_op_t mul_start;
    mul_op_t mul_take;
    logic    pid_finish;
    logic    emit;
  } dp_cmd_t;

  typedef struct packed {
    mode_t mode;
    logic  waiting;
    logic  period_long;
    logic  mul_done;
    logic  div_done;
    logic  out_free;
  } dp_status_t;

endpackage
`default_nettype wire

@@ hw/rtl/mspid_in_if.sv @@
`default_nettype none
interface mspid_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  mode;
  logic        enc_a;
  logic        enc_b;
  logic [31:0] time_us;
  logic [15:0] elapsed_ms;

  modport source (output valid, mode, enc_a, enc_b, time_us, elapsed_ms, input ready);
  modport sink (input valid, mode, enc_a, enc_b, time_us, elapsed_ms, output ready);
endinterface
`default_nettype wire

@@ hw/rtl/mspid_out_if.sv @@
`default_nettype none
interface mspid_out_if;
  logic               valid;
  logic               ready;
  logic [7:0]         drive;
  logic [14:0]        reference_rpm;
  logic [15:0]        speed_rpm;
  logic signed [16:0] speed_error;
  logic               armed_for_first;

  modport source (output valid, drive, reference_rpm, speed_rpm, speed_error,
                  armed_for_first, input ready);
  modport sink (input valid, drive, reference_rpm, speed_rpm, speed_error,
                armed_for_first, output ready);
endinterface
`default_nettype wire

@@ hw/rtl/mspid_mul.sv @@
`default_nettype none
module mspid_mul import mspid_pkg::*; #(
  parameter int A_W = 40
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         start,
  input  wire logic signed [A_W-1:0]        a,
  input  wire logic [MUL_B_W-1:0]           b,
  output logic                              busy,
  output logic                              done,
  output logic signed [A_W+MUL_B_W-1:0]     prod
);
  localparam int P_W = A_W + MUL_B_W;

  logic signed [P_W-1:0]   acc_r, mcand_r, pp;
  logic [MUL_B_W-1:0]      mplier_r;
  logic [MUL_CNT_W-1:0]    cnt_r;
  logic                    busy_r, done_r;

  assign pp = (mplier_r[0] ? mcand_r : P_W'(0)) + (mplier_r[1] ? (mcand_r <<< 1) : P_W'(0));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == MUL_CNT_W'(MUL_STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      acc_r    <= '0;
      mcand_r  <= P_W'(a);
      mplier_r <= b;
    end else if (busy_r) begin
      acc_r    <= acc_r + pp;
      mcand_r  <= mcand_r <<< 2;
      mplier_r <= mplier_r >> 2;
    end
  end

  assign busy = busy_r;
  assign done = done_r;
  assign prod = acc_r;
endmodule
`default_nettype wire

@@ hw/rtl/mspid_div.sv @@
`default_nettype none
module mspid_div import mspid_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  start,
  input  wire logic [DIV_NUM_W-1:0]  num,
  input  wire logic [DIV_DEN_W-1:0]  den,
  output logic                       done,
  output logic [DIV_NUM_W-1:0]       quot
);
  logic [DIV_NUM_W-1:0] nq_r;
  logic [DIV_DEN_W-1:0] rem_r, den_r;
  logic [DIV_DEN_W:0]   rem_sh, rem_sub;
  logic                 fits;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic                 busy_r, done_r;

  // The numerator shifts out at the top while quotient bits enter at the bottom.
  assign rem_sh  = {rem_r, nq_r[DIV_NUM_W-1]};
  assign rem_sub = rem_sh - {1'b0, den_r};
  assign fits    = rem_sh >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == DIV_CNT_W'(DIV_NUM_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      nq_r  <= num;
      den_r <= den;
      rem_r <= '0;
    end else if (busy_r) begin
      nq_r  <= {nq_r[DIV_NUM_W-2:0], fits};
      rem_r <= fits ? rem_sub[DIV_DEN_W-1:0] : rem_sh[DIV_DEN_W-1:0];
    end
  end

  assign done = done_r;
  assign quot = nq_r;
endmodule
`default_nettype wire

@@ hw/rtl/mspid_ctrl.sv @@
`default_nettype none
module mspid_ctrl import mspid_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire dp_status_t  status_i,
  output dp_cmd_t          cmd_o
);
  typedef enum logic [9:0] {
    S_IDLE      = 10'b00_0000_0001,
    S_DISPATCH  = 10'b00_0000_0010,
    S_DIV_SPD   = 10'b00_0000_0100,
    S_MUL_EMS   = 10'b00_0000_1000,
    S_MUL_DMS   = 10'b00_0001_0000,
    S_MUL_PROP  = 10'b00_0010_0000,
    S_MUL_INTEG = 10'b00_0100_0000,
    S_MUL_DERIV = 10'b00_1000_0000,
    S_PID_DEC   = 10'b01_0000_0000,
    S_FINISH    = 10'b10_0000_0000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd_o     = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd_o.load = 1'b1;
          state_nxt  = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        unique case (status_i.mode)
          MODE_ENCODER: begin
            cmd_o.enc = 1'b1;
            state_nxt = S_FINISH;
          end
          MODE_PULSE: begin
            if (status_i.waiting) begin
              cmd_o.pulse_arm = 1'b1;
              state_nxt       = S_FINISH;
            end else if (status_i.period_long) begin
              cmd_o.div_start = 1'b1;
              state_nxt       = S_DIV_SPD;
            end else begin
              cmd_o.pulse_upd = 1'b1;
              state_nxt       = S_FINISH;
            end
          end
          MODE_CONTROL: begin
            cmd_o.pid_init  = 1'b1;
            cmd_o.mul_start = MUL_EMS;
            state_nxt       = S_MUL_EMS;
          end
          default: state_nxt = S_FINISH;
        endcase
      end
      S_DIV_SPD: begin
        if (status_i.div_done) begin
          cmd_o.pulse_upd = 1'b1;
          cmd_o.use_quot  = 1'b1;
          state_nxt       = S_FINISH;
        end
      end
      S_MUL_EMS: begin
        if (status_i.mul_done) begin
          cmd_o.mul_take  = MUL_EMS;
          cmd_o.mul_start = MUL_DMS;
          state_nxt       = S_MUL_DMS;
        end
      end
      S_MUL_DMS: begin
        if (status_i.mul_done) begin
          cmd_o.mul_take  = MUL_DMS;
          cmd_o.mul_start = MUL_PROP;
          state_nxt       = S_MUL_PROP;
        end
      end
      S_MUL_PROP: begin
        if (status_i.mul_done) begin
          cmd_o.mul_take  = MUL_PROP;
          cmd_o.mul_start = MUL_INTEG;
          state_nxt       = S_MUL_INTEG;
        end
      end
      S_MUL_INTEG: begin
        if (status_i.mul_done) begin
          cmd_o.mul_take  = MUL_INTEG;
          cmd_o.mul_start = MUL_DERIV;
          state_nxt       = S_MUL_DERIV;
        end
      end
      S_MUL_DERIV: begin
        if (status_i.mul_done) begin
          cmd_o.mul_take = MUL_DERIV;
          state_nxt      = S_PID_DEC;
        end
      end
      S_PID_DEC: begin
        cmd_o.pid_finish = 1'b1;
        state_nxt        = S_FINISH;
      end
      S_FINISH: begin
        if (status_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end
endmodule
`default_nettype wire

@@ hw/rtl/mspid_dp.sv @@
`default_nettype none
`include "assert_macros.svh"
module mspid_dp import mspid_pkg::*; #(
  parameter int GAIN_FRAC_BITS = GAIN_FRAC_BITS_DEF,
  parameter int INTEGRAL_WIDTH = INTEGRAL_WIDTH_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   cfg_we,
  input  wire logic [CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data,
  input  wire logic [1:0]             in_mode,
  input  wire logic                   in_enc_a,
  input  wire logic                   in_enc_b,
  input  wire logic [31:0]            in_time_us,
  input  wire logic [15:0]            in_elapsed_ms,
  input  wire dp_cmd_t                cmd_i,
  output dp_status_t                  status_o,
  input  wire logic                   out_ready,
  output logic                        out_valid,
  output logic [7:0]                  out_drive,
  output logic [14:0]                 out_reference_rpm,
  output logic [15:0]                 out_speed_rpm,
  output logic signed [16:0]          out_speed_error,
  output logic                        out_armed_for_first
);
  localparam int IW  = INTEGRAL_WIDTH;
  localparam int AW  = (INTEGRAL_WIDTH > 36) ? INTEGRAL_WIDTH : 36;
  localparam int PW  = AW + MUL_B_W;
  localparam int SW  = PW + 1;
  localparam int DPW = DRIVE_NUM_W + DRIVE_RECIP_W;
  localparam logic signed [SW-1:0]  INT_HI   = (SW'(1) <<< (IW - 1)) - SW'(1);
  localparam logic signed [SW-1:0]  INT_LO   = -INT_HI - SW'(1);
  localparam logic signed [N_W-1:0] TERM_SAT = N_W'(1) <<< 60;
  localparam logic signed [N_W-1:0] N_LIMIT  = N_W'(255 * 1000) <<< GAIN_FRAC_BITS;

  // Configuration registers.
  logic [7:0]  rpm_step_r;
  logic [6:0]  max_steps_r;
  logic [15:0] gain_p_r, gain_i_r, gain_d_r, speed_limit_r;
  logic [31:0] timeout_r;

  // Latched input item.
  mode_t       mode_r;
  logic        enc_a_r, enc_b_r;
  logic [31:0] time_r;
  logic [15:0] ms_r;

  // Regulator state.
  logic [6:0]               step_r;
  logic [31:0]              last_r;
  logic                     waiting_r;
  logic [15:0]              speed_r;
  logic signed [IW-1:0]     integral_r;
  logic signed [17:0]       prev_r;
  logic [7:0]               drive_r;

  // Working registers of one control step.
  logic signed [16:0]       err_r;
  logic [15:0]              seen_r;
  logic signed [AW-1:0]     e1000_r, dms_r;
  logic signed [18:0]       d_r;
  logic signed [IW-1:0]     integ_r;
  logic signed [N_W-1:0]    n_r;

  logic                     out_valid_r;
  logic [7:0]               out_drive_r;
  logic [14:0]              out_ref_r;
  logic [15:0]              out_speed_r;
  logic signed [16:0]       out_err_r;
  logic                     out_armed_r;

  logic [14:0]              ref_now;
  logic signed [16:0]       err_now;
  logic signed [AW-1:0]     err_ext;
  logic [31:0]              period;
  logic [15:0]              spd_pick;
  logic                     speed_load;

  logic                     mul_start, mul_busy, mul_done;
  logic signed [AW-1:0]     mul_a;
  logic [MUL_B_W-1:0]       mul_b;
  logic signed [PW-1:0]     mul_prod;
  logic signed [N_W-1:0]    prod_n, integ_term;
  logic signed [SW-1:0]     integ_sum;
  logic signed [IW-1:0]     integ_nxt;

  logic                     div_done;
  logic [DIV_NUM_W-1:0]     div_num, div_quot;
  logic [DIV_DEN_W-1:0]     div_den;

  logic [DRIVE_NUM_W-1:0]   drive_num;
  logic [DPW-1:0]           drive_prod;

  assign ref_now    = 15'({8'd0, step_r} * {7'd0, rpm_step_r});
  assign err_now    = signed'({2'b00, ref_now}) - signed'({1'b0, speed_r});
  assign err_ext    = AW'(err_now);
  assign period     = time_r - last_r;
  assign spd_pick   = cmd_i.use_quot ? div_quot[15:0] : speed_r;
  assign speed_load = cmd_i.pulse_upd || cmd_i.pid_finish;

  always_comb begin
    mul_a = err_ext;
    mul_b = ms_r;
    case (cmd_i.mul_start)
      MUL_DMS: begin
        mul_a = AW'(d_r);
        mul_b = ms_r;
      end
      MUL_PROP: begin
        mul_a = e1000_r;
        mul_b = gain_p_r;
      end
      MUL_INTEG: begin
        mul_a = AW'(integ_r);
        mul_b = gain_i_r;
      end
      MUL_DERIV: begin
        mul_a = dms_r;
        mul_b = gain_d_r;
      end
      default: begin
        mul_a = err_ext;
        mul_b = ms_r;
      end
    endcase
  end
  assign mul_start = cmd_i.mul_start != MUL_NONE;

  mspid_mul #(.A_W(AW)) u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .busy  (mul_busy),
    .done  (mul_done),
    .prod  (mul_prod)
  );

  assign div_num = RPM_NUMERATOR;
  assign div_den = period;

  mspid_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd_i.div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quot  (div_quot)
  );

  // Between the rails n / 2^frac stays below 255000, so the reciprocal is exact.
  assign drive_num  = n_r[GAIN_FRAC_BITS +: DRIVE_NUM_W];
  assign drive_prod = {{DRIVE_RECIP_W{1'b0}}, drive_num} *
                      {{DRIVE_NUM_W{1'b0}}, DRIVE_RECIP};

  assign integ_sum = SW'(integral_r) + SW'(mul_prod);
  always_comb begin
    if (integ_sum > INT_HI) begin
      integ_nxt = IW'(INT_HI);
    end else if (integ_sum < INT_LO) begin
      integ_nxt = IW'(INT_LO);
    end else begin
      integ_nxt = IW'(integ_sum);
    end
  end

  assign prod_n = N_W'(mul_prod);
  always_comb begin
    if (prod_n > TERM_SAT) begin
      integ_term = TERM_SAT;
    end else if (prod_n < -TERM_SAT) begin
      integ_term = -TERM_SAT;
    end else begin
      integ_term = prod_n;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rpm_step_r    <= RST_RPM_PER_STEP;
      max_steps_r   <= RST_MAX_STEPS;
      gain_p_r      <= RST_GAIN;
      gain_i_r      <= RST_GAIN;
      gain_d_r      <= RST_GAIN;
      speed_limit_r <= RST_SPEED_LIMIT;
      timeout_r     <= RST_PULSE_TIMEOUT;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_RPM_PER_STEP:  rpm_step_r    <= cfg_data[7:0];
        CFG_MAX_STEPS:     max_steps_r   <= cfg_data[6:0];
        CFG_GAIN_P:        gain_p_r      <= cfg_data[15:0];
        CFG_GAIN_I:        gain_i_r      <= cfg_data[15:0];
        CFG_GAIN_D:        gain_d_r      <= cfg_data[15:0];
        CFG_SPEED_LIMIT:   speed_limit_r <= cfg_data[15:0];
        CFG_PULSE_TIMEOUT: timeout_r     <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_i.load) begin
      mode_r  <= mode_t'(in_mode);
      enc_a_r <= in_enc_a;
      enc_b_r <= in_enc_b;
      time_r  <= in_time_us;
      ms_r    <= in_elapsed_ms;
    end
    if (cmd_i.pid_init) begin
      err_r   <= err_now;
      seen_r  <= speed_r;
      e1000_r <= (err_ext <<< 10) - (err_ext <<< 4) - (err_ext <<< 3);
      d_r     <= 19'(err_now) - 19'(prev_r);
      n_r     <= '0;
    end
    case (cmd_i.mul_take)
      MUL_EMS:   integ_r <= integ_nxt;
      MUL_DMS:   dms_r   <= AW'(mul_prod);
      MUL_PROP:  n_r     <= n_r + prod_n;
      MUL_INTEG: n_r     <= n_r + integ_term;
      MUL_DERIV: n_r     <= n_r + prod_n;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r     <= '0;
      last_r     <= '0;
      waiting_r  <= 1'b1;
      speed_r    <= '0;
      integral_r <= '0;
      prev_r     <= '0;
      drive_r    <= '0;
    end else begin
      if (cmd_i.enc) begin
        if (enc_a_r != enc_b_r) begin
          if (step_r < max_steps_r) step_r <= step_r + 1'b1;
        end else if (step_r != '0) begin
          step_r <= step_r - 1'b1;
        end
      end
      if (cmd_i.pulse_arm) begin
        last_r    <= time_r;
        waiting_r <= 1'b0;
      end
      if (cmd_i.pulse_upd) begin
        if (cmd_i.use_quot) last_r <= time_r;
        speed_r <= (spd_pick > speed_limit_r) ? speed_limit_r : spd_pick;
      end
      if (cmd_i.pid_finish) begin
        if (n_r >= N_LIMIT) begin
          integral_r <= '0;
          prev_r     <= 18'(err_r);
          drive_r    <= DRIVE_MAX;
        end else if (n_r <= 0) begin
          integral_r <= integ_r;
          prev_r     <= '0;
          drive_r    <= '0;
        end else begin
          integral_r <= integ_r;
          prev_r     <= 18'(err_r);
          drive_r    <= drive_prod[DRIVE_SHIFT +: 8];
        end
        if (period > timeout_r) waiting_r <= 1'b1;
        speed_r <= '0;
      end
    end
  end

  // A control step reports the speed and error it regulated on, before clearing.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_i.emit) begin
      out_drive_r <= drive_r;
      out_ref_r   <= ref_now;
      out_armed_r <= waiting_r;
      if (mode_r == MODE_CONTROL) begin
        out_speed_r <= seen_r;
        out_err_r   <= err_r;
      end else begin
        out_speed_r <= speed_r;
        out_err_r   <= err_now;
      end
    end
  end

  assign status_o.mode        = mode_r;
  assign status_o.waiting     = waiting_r;
  assign status_o.period_long = period > MIN_PERIOD_US;
  assign status_o.mul_done    = mul_done;
  assign status_o.div_done    = div_done;
  assign status_o.out_free    = !out_valid_r || out_ready;

  assign out_valid           = out_valid_r;
  assign out_drive           = out_drive_r;
  assign out_reference_rpm   = out_ref_r;
  assign out_speed_rpm       = out_speed_r;
  assign out_speed_error     = out_err_r;
  assign out_armed_for_first = out_armed_r;

  `MSPID_ASSERT(a_mul_start_idle, clk, rst_n, (cmd_i.mul_start != MUL_NONE) |-> !mul_busy)
  `MSPID_ASSERT_NEXT(a_drive_only_on_pid, clk, rst_n, !cmd_i.pid_finish, $stable(drive_r))
  `MSPID_ASSERT_NEXT(a_speed_only_on_update, clk, rst_n, !speed_load, $stable(speed_r))
endmodule
`default_nettype wire

@@ hw/rtl/motor_speed_pid_controller.sv @@
// Motor speed regulator with a PID loop and anti-windup.
// Input channel in_if carries one item per event: mode selects an encoder
// change, a rotation pulse or a control step. Result channel out_if returns
// exactly one item per input item with drive, setpoint, measured speed,
// speed error and the re-arm flag. The user must write registers through
// cfg_we, cfg_index and cfg_data only while no item is in flight; the block
// does not enforce this. One item is worked on at a time; in_if.ready is
// high only while idle, and the next item can be taken in the cycle after
// the result is registered. An encoder change, an unused mode or a pulse
// that times no period needs neither divider nor multiplier; a timed pulse
// first runs the 23-step restoring divider, and a control step computes
// five products on the shared two-bit-per-cycle multiplier, one after
// another, then the drive decision, whose quotient comes from a reciprocal
// multiply.
// Synchronous reset clears the regulator state, loads the register defaults
// and empties the output register. When the receiver stalls, the finished
// result waits in the output register and the block holds the next result
// until that one is taken.
`default_nettype none
module motor_speed_pid_controller import mspid_pkg::*; #(
  parameter int GAIN_FRAC_BITS = GAIN_FRAC_BITS_DEF,
  parameter int INTEGRAL_WIDTH = INTEGRAL_WIDTH_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  mspid_in_if.sink                   in_if,
  mspid_out_if.source                out_if,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);
  dp_cmd_t    cmd;
  dp_status_t status;

  mspid_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_if.valid),
    .in_ready (in_if.ready),
    .status_i (status),
    .cmd_o    (cmd)
  );

  mspid_dp #(
    .GAIN_FRAC_BITS (GAIN_FRAC_BITS),
    .INTEGRAL_WIDTH (INTEGRAL_WIDTH)
  ) u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .in_mode             (in_if.mode),
    .in_enc_a            (in_if.enc_a),
    .in_enc_b            (in_if.enc_b),
    .in_time_us          (in_if.time_us),
    .in_elapsed_ms       (in_if.elapsed_ms),
    .cmd_i               (cmd),
    .status_o            (status),
    .out_ready           (out_if.ready),
    .out_valid           (out_if.valid),
    .out_drive           (out_if.drive),
    .out_reference_rpm   (out_if.reference_rpm),
    .out_speed_rpm       (out_if.speed_rpm),
    .out_speed_error     (out_if.speed_error),
    .out_armed_for_first (out_if.armed_for_first)
  );
endmodule
`default_nettype wire
